[hw/rtl/wavp_pkg.sv]
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Parse phases, result kinds, error codes and chunk tags shared by the parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

    typedef enum logic [4:0] {
        PH_RIFF,
        PH_RIFFSIZE,
        PH_WAVE,
        PH_CHUNK1,
        PH_JUNKSIZE,
        PH_JUNKSKIP,
        PH_CHUNK2,
        PH_FMTSIZE,
        PH_FMTTAG,
        PH_FMTCH,
        PH_FMTRATE,
        PH_BYTERATE,
        PH_ALIGN,
        PH_BITS,
        PH_CHUNK3,
        PH_LISTSIZE,
        PH_LISTSKIP,
        PH_CHUNK4,
        PH_DATASIZE,
        PH_SAMPLES,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NO_RIFF     = 3'd0,
        ERR_NO_WAVE     = 3'd1,
        ERR_NO_FMT      = 3'd2,
        ERR_UNSUPPORTED = 3'd3,
        ERR_NO_DATA     = 3'd4,
        ERR_NO_CHANNELS = 3'd5
    } err_t;

    // Tags as read little-endian into a 32-bit word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [31:0] FMT_PCM        = 32'd1;
    localparam logic [31:0] BITS_8         = 32'd8;
    localparam logic [31:0] BITS_16        = 32'd16;

endpackage

[hw/rtl/wav_pcm_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Parses a RIFF/WAVE byte stream and emits header, sample and error words.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | data_byte, start_of_file
//  output  | out_valid / out_ready| kind, sample, channel, last_sample,
//          |                      | rate_hz, channel_count, sample_bits,
//          |                      | stereo, error_code
//
//  One input byte is taken every cycle while in_ready is high; its result, if any, appears in the
//  output register on the next cycle.
//  The input side stalls only while a result waits in the output register and
//  out_ready is low; the result register is the only stage between the sides.
//  Reset returns the parser to waiting for the RIFF tag with no word pending.
//  Frame counting uses a remaining-sample counter with one subtract per frame.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_top
    import wavp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               start_of_file,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic               last_sample,
    output logic [31:0]        rate_hz,
    output logic [15:0]        channel_count,
    output logic [4:0]         sample_bits,
    output logic               stereo,
    output logic [2:0]         error_code
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbi_reg, fbi_next;
    logic [31:0] shift_reg, shift_next;
    logic        bad_reg, bad_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] chans_reg, chans_next;
    logic [4:0]  bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] rem_reg, rem_next;
    logic        lastf_reg, lastf_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  low_reg, low_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [15:0] sample_reg;
    logic        channel_reg;
    logic        last_reg;
    logic [31:0] rate_out_reg;
    logic [15:0] count_out_reg;
    logic [4:0]  bits_out_reg;
    logic        stereo_reg;
    logic [2:0]  err_reg;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [15:0] res_sample;
    logic        res_channel;
    logic        res_last;
    logic [31:0] res_rate;
    logic [15:0] res_count;
    logic [4:0]  res_bits;
    logic        res_stereo;
    logic [2:0]  res_err;

    logic        accept;
    phase_t      phase_cur;
    logic [1:0]  fbi_cur;
    logic [31:0] shift_cur;
    logic        bad_cur;
    logic        need2;
    logic        done;
    logic [31:0] v;
    logic [15:0] word;
    logic        lastch;
    logic [16:0] pos_inc;
    logic        frame_end;
    logic [32:0] rem_minus;
    logic [31:0] samples_total;
    logic [31:0] junk_skip;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // A start-of-file byte restarts the parser before it is taken.
        phase_cur = start_of_file ? PH_RIFF : phase_reg;
        fbi_cur   = start_of_file ? 2'd0 : fbi_reg;
        shift_cur = start_of_file ? 32'd0 : shift_reg;
        bad_cur   = start_of_file ? 1'b0 : bad_reg;

        need2 = (phase_cur == PH_FMTTAG) || (phase_cur == PH_FMTCH) ||
                (phase_cur == PH_ALIGN) || (phase_cur == PH_BITS);
        v     = shift_cur | ({24'd0, data_byte} << {fbi_cur, 3'b000});
        done  = need2 ? (fbi_cur != 2'd0) : (fbi_cur == 2'd3);

        lastch    = (chans_reg > 16'd1);
        word      = (bits_reg == BITS_16[4:0]) ? {data_byte, low_reg}
                                               : {~data_byte[7], data_byte[6:0], 8'd0};
        pos_inc   = {1'b0, pos_reg} + 17'd1;
        frame_end = (pos_inc >= {1'b0, chans_reg});
        rem_minus = {1'b0, rem_reg} - {17'd0, chans_reg};

        samples_total = (bits_reg == BITS_16[4:0]) ? {1'b0, v[31:1]} : v;
        junk_skip     = v + {31'd0, v[0]};

        phase_next = phase_cur;
        fbi_next   = fbi_cur;
        shift_next = shift_cur;
        bad_next   = bad_cur;
        skip_next  = skip_reg;
        chans_next = chans_reg;
        bits_next  = bits_reg;
        rate_next  = rate_reg;
        rem_next   = rem_reg;
        lastf_next = lastf_reg;
        pos_next   = pos_reg;
        low_next   = low_reg;

        res_valid   = 1'b0;
        res_kind    = KIND_SAMPLE;
        res_sample  = 16'd0;
        res_channel = 1'b0;
        res_last    = 1'b0;
        res_rate    = 32'd0;
        res_count   = 16'd0;
        res_bits    = 5'd0;
        res_stereo  = 1'b0;
        res_err     = ERR_NO_RIFF;

        unique case (phase_cur)
            PH_IDLE:
            begin
            end
            PH_JUNKSKIP, PH_LISTSKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = (phase_cur == PH_JUNKSKIP) ? PH_CHUNK2 : PH_CHUNK4;
                end
            end
            PH_SAMPLES:
            begin
                if ((bits_reg == BITS_16[4:0]) && (fbi_cur == 2'd0))
                begin
                    low_next = data_byte;
                    fbi_next = 2'd1;
                end
                else
                begin
                    fbi_next = 2'd0;
                    if (pos_reg < 16'd2)
                    begin
                        res_valid   = 1'b1;
                        res_kind    = KIND_SAMPLE;
                        res_sample  = word;
                        res_channel = pos_reg[0];
                        res_last    = (pos_reg[0] == lastch) && lastf_reg;
                        res_stereo  = lastch;
                    end
                    pos_next = pos_inc[15:0];
                    if (frame_end)
                    begin
                        // The frame just read was whole; see whether another follows.
                        pos_next   = 16'd0;
                        rem_next   = rem_minus[31:0];
                        lastf_next = (rem_minus[31:0] < {15'd0, chans_reg, 1'b0});
                        if (rem_minus[31:0] < {16'd0, chans_reg})
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                if (!done)
                begin
                    fbi_next   = fbi_cur + 2'd1;
                    shift_next = v;
                end
                else
                begin
                    fbi_next   = 2'd0;
                    shift_next = 32'd0;
                    res_kind   = KIND_ERROR;
                    priority case (phase_cur)
                        PH_RIFF:
                        begin
                            if (v != TAG_RIFF)
                            begin
                                res_valid  = 1'b1;
                                res_err    = ERR_NO_RIFF;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_RIFFSIZE;
                            end
                        end
                        PH_RIFFSIZE: phase_next = PH_WAVE;
                        PH_WAVE:
                        begin
                            if (v != TAG_WAVE)
                            begin
                                res_valid  = 1'b1;
                                res_err    = ERR_NO_WAVE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_CHUNK1;
                            end
                        end
                        PH_CHUNK1, PH_CHUNK2:
                        begin
                            if ((phase_cur == PH_CHUNK1) && (v == TAG_JUNK))
                            begin
                                phase_next = PH_JUNKSIZE;
                            end
                            else if (v != TAG_FMT)
                            begin
                                res_valid  = 1'b1;
                                res_err    = ERR_NO_FMT;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_FMTSIZE;
                            end
                        end
                        PH_JUNKSIZE:
                        begin
                            // An odd size is padded by one, wrapping at 32 bits.
                            skip_next  = junk_skip;
                            phase_next = (junk_skip == 32'd0) ? PH_CHUNK2 : PH_JUNKSKIP;
                        end
                        PH_FMTSIZE:
                        begin
                            bad_next   = (v != FMT_CHUNK_SIZE);
                            phase_next = PH_FMTTAG;
                        end
                        PH_FMTTAG:
                        begin
                            if (v != FMT_PCM)
                            begin
                                bad_next = 1'b1;
                            end
                            phase_next = PH_FMTCH;
                        end
                        PH_FMTCH:
                        begin
                            chans_next = v[15:0];
                            phase_next = PH_FMTRATE;
                        end
                        PH_FMTRATE:
                        begin
                            rate_next  = v;
                            phase_next = PH_BYTERATE;
                        end
                        PH_BYTERATE: phase_next = PH_ALIGN;
                        PH_ALIGN:    phase_next = PH_BITS;
                        PH_BITS:
                        begin
                            if (bad_cur || ((v != BITS_8) && (v != BITS_16)))
                            begin
                                res_valid  = 1'b1;
                                res_err    = ERR_UNSUPPORTED;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                bits_next = v[4:0];
                                if (chans_reg == 16'd0)
                                begin
                                    res_valid  = 1'b1;
                                    res_err    = ERR_NO_CHANNELS;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_CHUNK3;
                                end
                            end
                        end
                        PH_CHUNK3, PH_CHUNK4:
                        begin
                            if ((phase_cur == PH_CHUNK3) && (v == TAG_LIST))
                            begin
                                phase_next = PH_LISTSIZE;
                            end
                            else if (v != TAG_DATA)
                            begin
                                res_valid  = 1'b1;
                                res_err    = ERR_NO_DATA;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_DATASIZE;
                            end
                        end
                        PH_LISTSIZE:
                        begin
                            skip_next  = v;
                            phase_next = (v == 32'd0) ? PH_CHUNK4 : PH_LISTSKIP;
                        end
                        PH_DATASIZE:
                        begin
                            res_valid = 1'b1;
                            if (chans_reg == 16'd0)
                            begin
                                res_err    = ERR_NO_CHANNELS;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                res_kind   = KIND_HEADER;
                                res_rate   = rate_reg;
                                res_count  = chans_reg;
                                res_bits   = bits_reg;
                                res_stereo = lastch;
                                // Whole frames remain while samples_total covers a frame.
                                rem_next   = samples_total;
                                lastf_next = (samples_total < {15'd0, chans_reg, 1'b0});
                                pos_next   = 16'd0;
                                low_next   = 8'd0;
                                phase_next = (samples_total < {16'd0, chans_reg}) ?
                                             PH_IDLE : PH_SAMPLES;
                            end
                        end
                        default:     phase_next = PH_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            fbi_reg       <= 2'd0;
            shift_reg     <= 32'd0;
            bad_reg       <= 1'b0;
            skip_reg      <= 32'd0;
            chans_reg     <= 16'd0;
            bits_reg      <= 5'd0;
            rate_reg      <= 32'd0;
            rem_reg       <= 32'd0;
            lastf_reg     <= 1'b0;
            pos_reg       <= 16'd0;
            low_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                fbi_reg   <= fbi_next;
                shift_reg <= shift_next;
                bad_reg   <= bad_next;
                skip_reg  <= skip_next;
                chans_reg <= chans_next;
                bits_reg  <= bits_next;
                rate_reg  <= rate_next;
                rem_reg   <= rem_next;
                lastf_reg <= lastf_next;
                pos_reg   <= pos_next;
                low_reg   <= low_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= accept && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg      <= res_kind;
            sample_reg    <= res_sample;
            channel_reg   <= res_channel;
            last_reg      <= res_last;
            rate_out_reg  <= res_rate;
            count_out_reg <= res_count;
            bits_out_reg  <= res_bits;
            stereo_reg    <= res_stereo;
            err_reg       <= res_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign sample        = sample_reg;
    assign channel       = channel_reg;
    assign last_sample   = last_reg;
    assign rate_hz       = rate_out_reg;
    assign channel_count = count_out_reg;
    assign sample_bits   = bits_out_reg;
    assign stereo        = stereo_reg;
    assign error_code    = err_reg;

`ifndef SYNTHESIS
    // The right channel is only produced for a file with more than one channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_SAMPLE) && channel_reg) |-> stereo_reg)
        else $error("right-channel sample on a mono stream");

    // Sample phase is entered only after a nonzero channel count was read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SAMPLES) |-> (chans_reg != 16'd0))
        else $error("sample phase with zero channels");

    // A byte taken while idle, without a restart, produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_of_file && (phase_reg == PH_IDLE) && !out_valid_reg)
        |=> !out_valid_reg)
        else $error("result produced while idle");
`endif

endmodule
